// ===== rtl/core/owo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owo_pkg
// Shared widths, constants, arctangent table and sequencer types for the
// three-wheel omni drive odometry block.
// ----------------------------------------------------------------------------
package owo_pkg;

  // cordic iteration count, limited by the arctangent table
  localparam int ANGLE_BITS   = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITERS = (ANGLE_BITS > ATAN_ENTRIES) ? ATAN_ENTRIES : ANGLE_BITS;
  localparam int ITER_W       = $clog2(ATAN_ENTRIES);

  // field widths
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int IN_W    = 3 * SPEED_W;
  localparam int OUT_W   = 4 * SPEED_W + 2 * POS_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X    = 2'd0,
    REG_GAIN_Y    = 2'd1,
    REG_GAIN_W    = 2'd2,
    REG_STEP_TIME = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] STEP_TIME_RST = 16'd655;

  // wheel combination widths
  localparam int SX_W = 18;  // -2*w0 + w1 + w2
  localparam int SY_W = 17;  // w2 - w1
  localparam int SW_W = 18;  // w0 + w1 + w2

  // cordic datapath
  localparam int CW  = 34;   // x/y in Q2.30 with headroom
  localparam int ZW  = 33;   // residual angle
  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  // shared multiplier and accumulator
  localparam int MA_W   = 18;
  localparam int MB_W   = 35;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 72;
  localparam int T_W    = 32;  // turn * step_time

  // 2^32 / (2*pi), split for the narrow multiplier
  localparam logic [29:0] TURN_TO_ANGLE = 30'd683565276;
  localparam logic [16:0] K_LO = TURN_TO_ANGLE[16:0];
  localparam logic [12:0] K_HI = TURN_TO_ANGLE[29:17];

  // rounding and saturation constants
  localparam logic signed [PROD_W-1:0] VEL_RND = PROD_W'(2048);
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(32768);
  localparam logic signed [ACC_W-1:0]  RND40   = ACC_W'(1) <<< 39;
  localparam logic signed [ACC_W-1:0]  RND42   = ACC_W'(1) <<< 41;

  // sequencer program length
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd21;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_RUN,
    ST_DONE
  } state_t;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    M_NONE,
    M_GX,
    M_GY,
    M_GW,
    M_VXC,
    M_VYS,
    M_VXS,
    M_VYC,
    M_TDT,
    M_PHI,
    M_PLO,
    M_KLO,
    M_KHI
  } mul_sel_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_ADD,
    A_SUB,
    A_RND40,
    A_RND42
  } acc_op_t;

  typedef enum logic [1:0] {
    SH0,
    SH17,
    SH34
  } shift_t;

  typedef enum logic [3:0] {
    S_NONE,
    S_FLIP,
    S_VX,
    S_VY,
    S_TURN,
    S_T,
    S_XU,
    S_YU,
    S_HU
  } store_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    shift_t   sh;
    store_t   st;
  } ctl_t;

endpackage

// ===== rtl/core/omni_wheel_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_odometry
// Three-wheel omni forward kinematics and pose integration: body velocities
// from wheel speeds, heading rotation by an iterative cordic and Euler update
// of x, y and heading, all on one shared 18x35 multiplier and accumulator.
// ----------------------------------------------------------------------------
// Sequence: after the input transaction, 16 cordic iterations and 22
//   multiply-accumulate steps, then a hand-off state that loads the output
//   register once it is free or taken; out_tvalid rises when it is loaded.
// One item at a time: in_tready is low until the last one is handed off.
// A finished result waits in the output register while the next item runs.
// Reset (rst_n low, synchronous): pose, heading, gains cleared, step_time 655.
module omni_wheel_odometry (
  input  logic                          clk,
  input  logic                          rst_n,
  // wheel0_speed, wheel1_speed, wheel2_speed (from the lowest bit up)
  input  logic [owo_pkg::IN_W-1:0]      in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // body_vx, body_vy, body_turn_rate, pos_x, pos_y, heading_out
  output logic [owo_pkg::OUT_W-1:0]     out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import owo_pkg::*;

  // sequencer
  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  ctl_t              ctl;
  logic              in_acc;
  logic              load_out;
  logic              cordic_last;

  // configuration
  logic signed [GAIN_W-1:0] gain_x_r, gain_x_nxt;
  logic signed [GAIN_W-1:0] gain_y_r, gain_y_nxt;
  logic signed [GAIN_W-1:0] gain_w_r, gain_w_nxt;
  logic [15:0]              step_time_r, step_time_nxt;

  // pose state
  logic [POS_W-1:0]  x_r, x_nxt;
  logic [POS_W-1:0]  y_r, y_nxt;
  logic [HEAD_W-1:0] hd_r, hd_nxt;

  // per-item working registers
  logic                     flip_r, flip_nxt;
  logic signed [SX_W-1:0]   sx_r, sx_nxt;
  logic signed [SY_W-1:0]   sy_r, sy_nxt;
  logic signed [SW_W-1:0]   sw_r, sw_nxt;
  logic signed [CW-1:0]     cx_r, cx_nxt;
  logic signed [CW-1:0]     cy_r, cy_nxt;
  logic signed [ZW-1:0]     cz_r, cz_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [T_W-1:0]    t_r, t_nxt;
  logic signed [15:0]       vx_r, vx_nxt;
  logic signed [15:0]       vy_r, vy_nxt;
  logic signed [15:0]       turn_r, turn_nxt;

  // output register
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  // datapath temporaries
  logic signed [SPEED_W-1:0] w0, w1, w2;
  logic signed [MA_W-1:0]    ma;
  logic signed [MB_W-1:0]    mb;
  logic signed [MA_W-1:0]    dt_a;
  logic signed [MB_W-1:0]    dt_b;
  logic signed [CW-1:0]      xs, ys;
  logic signed [ZW-1:0]      atan_z;
  logic signed [ACC_W-1:0]   acc_base, acc_opnd, prod_ext;
  logic signed [15:0]        vel_sat;

  // round and clamp a gain product to a 16-bit velocity
  function automatic logic signed [15:0] sat_vel(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + VEL_RND) >>> 12;
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end else if (r < SAT_MIN) begin
      r = SAT_MIN;
    end
    return signed'(r[15:0]);
  endfunction

  assign in_acc      = in_tvalid && in_tready;
  assign cordic_last = (iter_r == ITER_W'(CORDIC_ITERS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cordic_last) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (step_r == LAST_STEP) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs and step program
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    load_out  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);
    ctl       = '{mul: M_NONE, acc: A_NONE, sh: SH0, st: S_NONE};
    if (state_r == ST_RUN) begin
      case (step_r)
        5'd0:  ctl = '{mul: M_GX,   acc: A_NONE,  sh: SH0,  st: S_FLIP};
        5'd1:  ctl = '{mul: M_GY,   acc: A_NONE,  sh: SH0,  st: S_VX};
        5'd2:  ctl = '{mul: M_GW,   acc: A_NONE,  sh: SH0,  st: S_VY};
        5'd3:  ctl = '{mul: M_VXC,  acc: A_NONE,  sh: SH0,  st: S_TURN};
        5'd4:  ctl = '{mul: M_VYS,  acc: A_LOAD,  sh: SH0,  st: S_NONE};
        5'd5:  ctl = '{mul: M_TDT,  acc: A_SUB,   sh: SH0,  st: S_NONE};
        5'd6:  ctl = '{mul: M_PHI,  acc: A_NONE,  sh: SH0,  st: S_T};
        5'd7:  ctl = '{mul: M_PLO,  acc: A_LOAD,  sh: SH34, st: S_NONE};
        5'd8:  ctl = '{mul: M_NONE, acc: A_ADD,   sh: SH0,  st: S_NONE};
        5'd9:  ctl = '{mul: M_NONE, acc: A_RND40, sh: SH0,  st: S_NONE};
        5'd10: ctl = '{mul: M_VXS,  acc: A_NONE,  sh: SH0,  st: S_XU};
        5'd11: ctl = '{mul: M_VYC,  acc: A_LOAD,  sh: SH0,  st: S_NONE};
        5'd12: ctl = '{mul: M_NONE, acc: A_ADD,   sh: SH0,  st: S_NONE};
        5'd13: ctl = '{mul: M_PHI,  acc: A_NONE,  sh: SH0,  st: S_NONE};
        5'd14: ctl = '{mul: M_PLO,  acc: A_LOAD,  sh: SH34, st: S_NONE};
        5'd15: ctl = '{mul: M_NONE, acc: A_ADD,   sh: SH0,  st: S_NONE};
        5'd16: ctl = '{mul: M_NONE, acc: A_RND40, sh: SH0,  st: S_NONE};
        5'd17: ctl = '{mul: M_KLO,  acc: A_NONE,  sh: SH0,  st: S_YU};
        5'd18: ctl = '{mul: M_KHI,  acc: A_LOAD,  sh: SH0,  st: S_NONE};
        5'd19: ctl = '{mul: M_NONE, acc: A_ADD,   sh: SH17, st: S_NONE};
        5'd20: ctl = '{mul: M_NONE, acc: A_RND42, sh: SH0,  st: S_NONE};
        5'd21: ctl = '{mul: M_NONE, acc: A_NONE,  sh: SH0,  st: S_HU};
        default: ctl = '{mul: M_NONE, acc: A_NONE, sh: SH0, st: S_NONE};
      endcase
    end
  end

  // counters
  always_comb begin
    iter_nxt = iter_r;
    step_nxt = step_r;
    if (in_acc) begin
      iter_nxt = '0;
    end else if (state_r == ST_CORDIC) begin
      iter_nxt = iter_r + ITER_W'(1);
    end
    if (state_r == ST_CORDIC) begin
      step_nxt = '0;
    end else if (state_r == ST_RUN) begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  // configuration writes
  always_comb begin
    cfg_ready     = 1'b1;
    gain_x_nxt    = gain_x_r;
    gain_y_nxt    = gain_y_r;
    gain_w_nxt    = gain_w_r;
    step_time_nxt = step_time_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_X:    gain_x_nxt    = signed'(cfg_data);
        REG_GAIN_Y:    gain_y_nxt    = signed'(cfg_data);
        REG_GAIN_W:    gain_w_nxt    = signed'(cfg_data);
        REG_STEP_TIME: step_time_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier operand selection
  always_comb begin
    dt_a = MA_W'(signed'({1'b0, step_time_r}));
    dt_b = MB_W'(signed'({1'b0, step_time_r}));
    ma   = '0;
    mb   = '0;
    case (ctl.mul)
      M_GX:  begin ma = MA_W'(gain_x_r); mb = MB_W'(sx_r); end
      M_GY:  begin ma = MA_W'(gain_y_r); mb = MB_W'(sy_r); end
      M_GW:  begin ma = MA_W'(gain_w_r); mb = MB_W'(sw_r); end
      M_VXC: begin ma = MA_W'(vx_r);     mb = MB_W'(cx_r); end
      M_VYS: begin ma = MA_W'(vy_r);     mb = MB_W'(cy_r); end
      M_VXS: begin ma = MA_W'(vx_r);     mb = MB_W'(cy_r); end
      M_VYC: begin ma = MA_W'(vy_r);     mb = MB_W'(cx_r); end
      M_TDT: begin ma = MA_W'(turn_r);   mb = dt_b;        end
      // upper part of the rotated velocity sum, times step_time
      M_PHI: begin ma = MA_W'(signed'(acc_r[50:34])); mb = dt_b; end
      // lower 34 bits of the sum, unsigned, times step_time
      M_PLO: begin ma = dt_a; mb = signed'({1'b0, acc_r[33:0]}); end
      M_KLO: begin ma = MA_W'(signed'({1'b0, K_LO})); mb = MB_W'(t_r); end
      M_KHI: begin ma = MA_W'(signed'({1'b0, K_HI})); mb = MB_W'(t_r); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod_nxt = PROD_W'(ma) * PROD_W'(mb);
  end

  // accumulator: one adder, operand chosen by the step
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    case (ctl.sh)
      SH17:    acc_opnd = prod_ext <<< 17;
      SH34:    acc_opnd = prod_ext <<< 34;
      default: acc_opnd = prod_ext;
    endcase
    acc_base = acc_r;
    case (ctl.acc)
      A_LOAD:  acc_base = '0;
      A_RND40: acc_opnd = RND40;
      A_RND42: acc_opnd = RND42;
      default: ;
    endcase
    case (ctl.acc)
      A_NONE:  acc_nxt = acc_r;
      A_SUB:   acc_nxt = acc_base - acc_opnd;
      default: acc_nxt = acc_base + acc_opnd;
    endcase
  end

  // input capture, cordic iterations and stores
  always_comb begin
    w0 = signed'(in_tdata[15:0]);
    w1 = signed'(in_tdata[31:16]);
    w2 = signed'(in_tdata[47:32]);

    xs     = cx_r >>> iter_r;
    ys     = cy_r >>> iter_r;
    atan_z = ZW'(signed'({1'b0, atan_turn(iter_r)}));
    vel_sat = sat_vel(prod_r);

    flip_nxt = flip_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    sw_nxt   = sw_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    cz_nxt   = cz_r;
    t_nxt    = t_r;
    vx_nxt   = vx_r;
    vy_nxt   = vy_r;
    turn_nxt = turn_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    hd_nxt   = hd_r;

    if (in_acc) begin
      // wheel combinations
      sx_nxt = -(SX_W'(w0) <<< 1) + SX_W'(w1) + SX_W'(w2);
      sy_nxt = SY_W'(w2) - SY_W'(w1);
      sw_nxt = SW_W'(w0) + SW_W'(w1) + SW_W'(w2);
      // left half-plane headings are turned by pi and negated at the end
      flip_nxt = hd_r[15] ^ hd_r[14];
      cx_nxt   = CORDIC_K;
      cy_nxt   = '0;
      cz_nxt   = ZW'(signed'({hd_r[14], hd_r[14:0], 16'b0}));
    end else if (state_r == ST_CORDIC) begin
      if (!cz_r[ZW-1]) begin
        cx_nxt = cx_r - ys;
        cy_nxt = cy_r + xs;
        cz_nxt = cz_r - atan_z;
      end else begin
        cx_nxt = cx_r + ys;
        cy_nxt = cy_r - xs;
        cz_nxt = cz_r + atan_z;
      end
    end

    case (ctl.st)
      S_FLIP: begin
        if (flip_r) begin
          cx_nxt = -cx_r;
          cy_nxt = -cy_r;
        end
      end
      S_VX:   vx_nxt   = vel_sat;
      S_VY:   vy_nxt   = vel_sat;
      S_TURN: turn_nxt = vel_sat;
      S_T:    t_nxt    = signed'(prod_r[T_W-1:0]);
      S_XU:   x_nxt    = x_r + acc_r[71:40];
      S_YU:   y_nxt    = y_r + acc_r[71:40];
      S_HU:   hd_nxt   = hd_r + acc_r[57:42];
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r;
    if (load_out) begin
      out_tdata_nxt  = {hd_r, y_r, x_r, turn_r, vy_r, vx_r};
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      iter_r       <= '0;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
      gain_x_r     <= '0;
      gain_y_r     <= '0;
      gain_w_r     <= '0;
      step_time_r  <= STEP_TIME_RST;
      x_r          <= '0;
      y_r          <= '0;
      hd_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      iter_r       <= iter_nxt;
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      gain_x_r     <= gain_x_nxt;
      gain_y_r     <= gain_y_nxt;
      gain_w_r     <= gain_w_nxt;
      step_time_r  <= step_time_nxt;
      x_r          <= x_nxt;
      y_r          <= y_nxt;
      hd_r         <= hd_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    flip_r      <= flip_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    sw_r        <= sw_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    t_r         <= t_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    turn_r      <= turn_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

// ===== dv/tb_omni_wheel_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_omni_wheel_odometry
// Self-checking bench for the omni wheel odometry block. Wheel speed samples
// are streamed in under several gain and step settings, with random idling
// on both sides. Each pose result is checked against an in-bench model of
// the velocity, cordic rotation and Euler pose update.
// ----------------------------------------------------------------------------
module tb_omni_wheel_odometry;
  import owo_pkg::*;

  // arctangent of 2^-i as a 32-bit binary angle
  localparam longint ATAN_TBL [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };
  localparam longint GAIN_Q230     = 652032874;
  localparam longint RAD_TO_BAMS   = 683565276;
  localparam int     DRAIN_CYCLES  = 60;
  localparam int     RAND_PHASES   = 8;
  localparam int     PHASE_SAMPLES = 104;

  typedef struct packed {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] turn;
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] hd;
  } pose_result_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_W-1:0]       in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow registers and pose state of the model
  logic signed [15:0] gain_x_q, gain_y_q, gain_w_q;
  logic [15:0]        step_time_q;
  logic [31:0]        pose_x, pose_y;
  logic [15:0]        pose_hd;

  logic [IN_W-1:0] wheel_q [$];
  pose_result_t    pose_q [$];
  logic            wheel_busy;
  logic            wheel_taken;
  int              send_idle_pct;
  int              stall_pct;
  int              err_cnt;
  int              samples_sent;
  int              results_seen;
  int              cfg_writes;

  omni_wheel_odometry uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // rounding right shift with floor
  function automatic longint round_shr(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_vel(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // cordic cos/sin of a 16-bit binary angle, Q2.30
  function automatic void heading_cos_sin(input logic [15:0] hd, output longint c,
                                          output longint s);
    logic [31:0] ang;
    logic        flip;
    longint      cx, sy, z, xs, ys;
    int          i;
    ang  = {hd, 16'h0000};
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang + 32'h8000_0000;
    z  = {{32{ang[31]}}, ang};
    cx = GAIN_Q230;
    sy = 0;
    for (i = 0; i < CORDIC_ITERS; i++) begin
      xs = cx >>> i;
      ys = sy >>> i;
      if (z >= 0) begin
        cx = cx - ys;
        sy = sy + xs;
        z  = z - ATAN_TBL[i];
      end else begin
        cx = cx + ys;
        sy = sy - xs;
        z  = z + ATAN_TBL[i];
      end
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    c = cx;
    s = sy;
  endfunction

  // body velocities and pose update for one wheel sample
  function automatic pose_result_t predict_pose(input logic signed [15:0] w0, w1, w2);
    pose_result_t r;
    longint a0, a1, a2, gx, gy, gw, dt, vx, vy, turn, c, s, dx, dy, dh;
    a0 = w0;
    a1 = w1;
    a2 = w2;
    gx = gain_x_q;
    gy = gain_y_q;
    gw = gain_w_q;
    dt = step_time_q;
    vx   = clamp_vel(round_shr(gx * (-2 * a0 + a1 + a2), 12));
    vy   = clamp_vel(round_shr(gy * (a2 - a1), 12));
    turn = clamp_vel(round_shr(gw * (a0 + a1 + a2), 12));
    // rotate by the heading held before this sample
    heading_cos_sin(pose_hd, c, s);
    dx = round_shr((vx * c - vy * s) * dt, 40);
    dy = round_shr((vx * s + vy * c) * dt, 40);
    dh = round_shr(turn * dt * RAD_TO_BAMS, 42);
    pose_x  = pose_x + dx[31:0];
    pose_y  = pose_y + dy[31:0];
    pose_hd = pose_hd + dh[15:0];
    r.vx   = vx[15:0];
    r.vy   = vy[15:0];
    r.turn = turn[15:0];
    r.px   = pose_x;
    r.py   = pose_y;
    r.hd   = pose_hd;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // input driver: holds each sample until its transaction completes
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (wheel_taken) begin
        wheel_taken = 1'b0;
        wheel_busy  = 1'b0;
      end
      if (!wheel_busy) begin
        if (wheel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata   <= wheel_q.pop_front();
          in_tvalid  <= 1'b1;
          wheel_busy = 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predicts on input transactions, checks result transactions
  always @(posedge clk) begin
    pose_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pose_q.push_back(predict_pose(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]));
        wheel_taken = 1'b1;
        samples_sent++;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pose_q.size() == 0) begin
          $error("unexpected result transaction: 0x%0h", out_tdata);
          err_cnt++;
        end else begin
          want = pose_q.pop_front();
          check_field("body_vx", want.vx, out_tdata[15:0]);
          check_field("body_vy", want.vy, out_tdata[31:16]);
          check_field("body_turn_rate", want.turn, out_tdata[47:32]);
          check_field("pos_x", want.px, out_tdata[79:48]);
          check_field("pos_y", want.py, out_tdata[111:80]);
          check_field("heading_out", want.hd, out_tdata[127:112]);
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_X:    gain_x_q = val;
      REG_GAIN_Y:    gain_y_q = val;
      REG_GAIN_W:    gain_w_q = val;
      REG_STEP_TIME: step_time_q = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_gains(input logic [15:0] gx, gy, gw, st);
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_Y, gy);
    write_reg(REG_GAIN_W, gw);
    write_reg(REG_STEP_TIME, st);
  endtask

  // wait until no sample is queued, in flight or awaiting its result
  task automatic wait_idle();
    do @(negedge clk);
    while (wheel_q.size() != 0 || wheel_busy || pose_q.size() != 0);
  endtask

  task automatic queue_wheels(input logic [15:0] w0, w1, w2);
    wheel_q.push_back({w2, w1, w0});
  endtask

  // wide, small, medium or extreme values
  function automatic logic [15:0] pick_word();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(4000)) - 16'd2000;
      2: begin
        case ($urandom_range(4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'hffff;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default: return 16'($urandom_range(16383)) - 16'd8192;
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(2000));
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    int p, k;
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_GAIN_X;
    cfg_data    = '0;
    wheel_busy  = 1'b0;
    wheel_taken = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    err_cnt       = 0;
    samples_sent  = 0;
    results_seen  = 0;
    cfg_writes    = 0;
    gain_x_q    = '0;
    gain_y_q    = '0;
    gain_w_q    = '0;
    step_time_q = STEP_TIME_RST;
    pose_x      = '0;
    pose_y      = '0;
    pose_hd     = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero gains give zero velocities
    queue_wheels(16'h7fff, 16'h8000, 16'h1234);
    queue_wheels(16'h8000, 16'h7fff, 16'hffff);
    wait_idle();

    // extreme gains, longest step: saturation and large heading jumps
    set_gains(16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
    queue_wheels(16'h0000, 16'h0000, 16'h0000);
    queue_wheels(16'h7fff, 16'h7fff, 16'h7fff);
    queue_wheels(16'h8000, 16'h8000, 16'h8000);
    queue_wheels(16'h8000, 16'h7fff, 16'h7fff);
    queue_wheels(16'h7fff, 16'h8000, 16'h8000);
    queue_wheels(16'h0000, 16'h8000, 16'h7fff);
    queue_wheels(16'h0000, 16'h7fff, 16'h8000);
    queue_wheels(16'hffff, 16'h0001, 16'hffff);
    wait_idle();

    // zero step time: pose frozen, velocities still reported
    set_gains(16'h8000, 16'h7fff, 16'h8000, 16'h0000);
    queue_wheels(16'h7fff, 16'h8000, 16'h7fff);
    queue_wheels(16'h1234, 16'hedcb, 16'h0400);
    queue_wheels(16'h8000, 16'h8000, 16'h7fff);
    queue_wheels(16'h0001, 16'hffff, 16'h0000);
    wait_idle();

    // nominal gains, small speeds
    set_gains(16'd4096, 16'd4730, 16'd1365, 16'd655);
    queue_wheels(16'd1024, 16'd1024, 16'd1024);
    queue_wheels(16'd0, -16'sd1024, 16'd1024);
    queue_wheels(-16'sd2048, 16'd1024, 16'd1024);
    queue_wheels(16'd100, 16'd200, -16'sd300);
    queue_wheels(16'hffff, 16'hffff, 16'hffff);
    queue_wheels(16'd500, 16'd0, 16'd0);
    wait_idle();

    // random phases, each under its own settings and idling pattern
    for (p = 0; p < RAND_PHASES; p++) begin
      set_gains(pick_word(), pick_word(), pick_word(), pick_step());
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      for (k = 0; k < PHASE_SAMPLES; k++)
        queue_wheels(pick_word(), pick_word(), pick_word());
      wait_idle();
    end

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pose_q.size() != 0) begin
      $error("%0d predicted results never arrived", pose_q.size());
      err_cnt++;
    end
    $display("odometry run: %0d wheel samples in, %0d pose results checked",
             samples_sent, results_seen);
    $display("settings: %0d register writes, idling patterns none/sender/receiver/both",
             cfg_writes);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
